// ===== rtl/core/sprx_pkg.sv =====
package sprx_pkg;

  localparam logic [7:0] SYNC_BYTE     = 8'hAA;
  localparam logic [7:0] RAW_CODE      = 8'h80;
  localparam logic [7:0] RESET_MAX_LEN = 8'd169;
  localparam int         MAX_RESULTS   = 42;
  localparam int         CNT_W         = 6;
  // Payload position and row end, wide enough for pos + 2 + 255
  localparam int         POS_W         = 9;
  localparam int         STOP_W        = 10;

  // Read address select for the payload store
  typedef enum logic [1:0] {
    RD_POS,
    RD_POS1,
    RD_FIRST,
    RD_FIRST1
  } rd_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    len_load;   // load frame length, clear count and sum
    logic    data_wr;    // store payload byte, update sum and count
    logic    walk_init;  // start the row walk at position zero
    logic    rd_en;      // read the payload store
    rd_sel_t rd_sel;
    logic    code_ld;    // latch row code from read data
    logic    hi_ld;      // latch high value byte from read data
    logic    pos_add2;   // skip a short row
    logic    pos_skip;   // jump to the end of the row just read
    logic    stop_ld;    // latch end of the row just read
    logic    raw_take;   // capture a raw value, advance to stored row end
    logic    flush;      // release the held value as last of frame
  } sprx_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic sync_match;
    logic len_bad;
    logic len_zero;
    logic data_done;
    logic sum_match;
    logic pos_lt_len;
    logic code_lt_raw;
    logic pos1_ge_len;
    logic stop_gt_len;
    logic raw_ok;
    logic count_last;
    logic have_pending;
    logic out_free;
  } sprx_status_t;

endpackage

// ===== rtl/core/sensor_packet_raw_extractor_unit.sv =====
// Sensor packet raw-value extractor.
// Input channel: one received serial byte per request on in_rx_byte, taken
// when in_valid is high and in_stall is low. The block hunts for two sync
// bytes, reads the length, stores and sums the payload and checks the
// checksum byte. Header, payload and checksum bytes are taken one per cycle.
// After a good checksum the block walks the stored rows and holds in_stall
// high meanwhile: short rows are stepped over, other long rows skipped to
// their end, and raw rows read for their first two value bytes, until the
// rows run out, a truncated row is met or the result cap is reached. The
// single read port of the payload store paces the walk. Each raw row with at
// least two value bytes yields one request on the output channel
// (out_raw_value, out_last_of_frame); a result is held until the next raw row
// is captured or the walk ends, so the last of a frame can be marked.
// Output channel: out_valid with out_stall from the receiver; a stalled
// result holds, and the walk waits for the output register to empty.
// Configuration: cfg_max_payload_length is written when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write only while idle.
// Reset (rst_n low, synchronous): the block hunts for the first sync byte,
// the length limit returns to 169, and no result is pending.
module sensor_packet_raw_extractor_unit #(
  parameter int PAYLOAD_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_raw_value,
  output logic        out_last_of_frame,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_max_payload_length
);
  import sprx_pkg::*;

  sprx_cmd_t    cmd;
  sprx_status_t status;
  logic         cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  sprx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sprx_datapath #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .rx_byte           (in_rx_byte),
    .cfg_wr            (cfg_wr),
    .cfg_data          (cfg_max_payload_length),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_raw_value     (out_raw_value),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

// ===== rtl/core/sprx_datapath.sv =====
module sprx_datapath #(
  parameter int PAYLOAD_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            rx_byte,
  input  logic                  cfg_wr,
  input  logic [7:0]            cfg_data,
  input  sprx_pkg::sprx_cmd_t   cmd,
  output sprx_pkg::sprx_status_t status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_raw_value,
  output logic                  out_last_of_frame
);
  import sprx_pkg::*;

  localparam int         AW        = $clog2(PAYLOAD_DEPTH);
  localparam logic [8:0] DEPTH_LIM = 9'(PAYLOAD_DEPTH);

  logic [7:0]        max_len_r;
  logic [7:0]        frame_len_r;
  logic [7:0]        rcv_cnt_r;
  logic [7:0]        sum_r;
  logic [7:0]        mem [PAYLOAD_DEPTH];
  logic [7:0]        rd_data_r;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  stop_r;
  logic [7:0]        code_r;
  logic [7:0]        hi_r;
  logic [CNT_W-1:0]  count_r;
  logic [15:0]       pend_r;
  logic              have_pend_r;
  logic              out_valid_r;
  logic [15:0]       out_value_r;
  logic              out_last_r;

  logic [POS_W-1:0]  rd_addr_full;
  logic [STOP_W-1:0] stop_nxt;
  logic [STOP_W-1:0] len_ext;
  logic              out_take;
  logic              push;

  assign len_ext  = STOP_W'(frame_len_r);
  // End of the current row: code, length byte, then the value bytes
  assign stop_nxt = STOP_W'(pos_r) + STOP_W'(2) + STOP_W'(rd_data_r);

  // Select the read address
  always_comb begin
    case (cmd.rd_sel)
      RD_POS:    rd_addr_full = pos_r;
      RD_POS1:   rd_addr_full = pos_r + POS_W'(1);
      RD_FIRST:  rd_addr_full = pos_r + POS_W'(2);
      RD_FIRST1: rd_addr_full = pos_r + POS_W'(3);
      default:   rd_addr_full = pos_r;
    endcase
  end

  // Payload store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.data_wr) begin
      mem[rcv_cnt_r[AW-1:0]] <= rx_byte;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr_full[AW-1:0]];
    end
  end

  assign out_take = out_valid_r && !out_stall;
  assign push     = (cmd.raw_take && have_pend_r) || (cmd.flush && have_pend_r);

  // Status toward the controller
  always_comb begin
    status.sync_match   = (rx_byte == SYNC_BYTE);
    status.len_bad      = (rx_byte > max_len_r) || ({1'b0, rx_byte} > DEPTH_LIM);
    status.len_zero     = (rx_byte == 8'd0);
    status.data_done    = ({1'b0, rcv_cnt_r} + 9'd1) >= {1'b0, frame_len_r};
    status.sum_match    = (rx_byte == ~sum_r);
    status.pos_lt_len   = pos_r < POS_W'(frame_len_r);
    status.code_lt_raw  = rd_data_r < RAW_CODE;
    status.pos1_ge_len  = (pos_r + POS_W'(1)) >= POS_W'(frame_len_r);
    status.stop_gt_len  = stop_nxt > len_ext;
    status.raw_ok       = (code_r == RAW_CODE) && (rd_data_r >= 8'd2)
                          && (count_r < CNT_W'(MAX_RESULTS));
    status.count_last   = (count_r == CNT_W'(MAX_RESULTS - 1));
    status.have_pending = have_pend_r;
    status.out_free     = !out_valid_r || !out_stall;
  end

  // Control registers: limit, held value flag, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= RESET_MAX_LEN;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        max_len_r <= cfg_data;
      end
      if (cmd.walk_init || cmd.flush) begin
        have_pend_r <= 1'b0;
      end else if (cmd.raw_take) begin
        have_pend_r <= 1'b1;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Frame header, walk position and result payload
  always_ff @(posedge clk) begin
    if (cmd.len_load) begin
      frame_len_r <= rx_byte;
      rcv_cnt_r   <= 8'd0;
      sum_r       <= 8'd0;
    end else if (cmd.data_wr) begin
      rcv_cnt_r <= rcv_cnt_r + 8'd1;
      sum_r     <= sum_r + rx_byte;
    end

    if (cmd.walk_init) begin
      pos_r   <= '0;
      count_r <= '0;
    end else if (cmd.pos_add2) begin
      pos_r <= pos_r + POS_W'(2);
    end else if (cmd.pos_skip) begin
      pos_r <= stop_nxt[POS_W-1:0];
    end else if (cmd.raw_take) begin
      pos_r   <= stop_r;
      count_r <= count_r + CNT_W'(1);
    end

    if (cmd.code_ld) begin
      code_r <= rd_data_r;
    end
    if (cmd.stop_ld) begin
      stop_r <= stop_nxt[POS_W-1:0];
    end
    if (cmd.hi_ld) begin
      hi_r <= rd_data_r;
    end
    if (cmd.raw_take) begin
      pend_r <= {hi_r, rd_data_r};
    end
    if (push) begin
      out_value_r <= pend_r;
      out_last_r  <= cmd.flush;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_raw_value     = out_value_r;
  assign out_last_of_frame = out_last_r;

endmodule

// ===== rtl/core/sprx_ctrl.sv =====
module sprx_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  sprx_pkg::sprx_status_t status,
  output sprx_pkg::sprx_cmd_t    cmd
);
  import sprx_pkg::*;

  typedef enum logic [3:0] {
    S_SYNC1,
    S_SYNC2,
    S_LEN,
    S_DATA,
    S_CHECK,
    W_RD,
    W_CODE,
    W_VLEN,
    W_HI,
    W_LO,
    W_FLUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   walking;
  logic   accept;

  assign walking  = (state_r == W_RD) || (state_r == W_CODE) || (state_r == W_VLEN)
                    || (state_r == W_HI) || (state_r == W_LO) || (state_r == W_FLUSH);
  assign in_stall = walking;
  assign accept   = in_valid && !walking;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_POS;
    case (state_r)
      S_SYNC1: begin
        if (accept && status.sync_match) state_nxt = S_SYNC2;
      end
      S_SYNC2: begin
        if (accept) state_nxt = status.sync_match ? S_LEN : S_SYNC1;
      end
      S_LEN: begin
        if (accept) begin
          if (status.len_bad) begin
            state_nxt = S_SYNC1;
          end else begin
            cmd.len_load = 1'b1;
            state_nxt    = status.len_zero ? S_CHECK : S_DATA;
          end
        end
      end
      S_DATA: begin
        if (accept) begin
          cmd.data_wr = 1'b1;
          if (status.data_done) state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (accept) begin
          if (status.sum_match) begin
            cmd.walk_init = 1'b1;
            state_nxt     = W_RD;
          end else begin
            state_nxt = S_SYNC1;
          end
        end
      end
      // Fetch the code byte of the next row
      W_RD: begin
        if (status.pos_lt_len) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_POS;
          state_nxt  = W_CODE;
        end else begin
          state_nxt = W_FLUSH;
        end
      end
      W_CODE: begin
        if (status.code_lt_raw) begin
          cmd.pos_add2 = 1'b1;
          state_nxt    = W_RD;
        end else if (status.pos1_ge_len) begin
          state_nxt = W_FLUSH;
        end else begin
          cmd.code_ld = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_POS1;
          state_nxt   = W_VLEN;
        end
      end
      // Length byte in hand: check the row fits, then read or skip it
      W_VLEN: begin
        if (status.stop_gt_len) begin
          state_nxt = W_FLUSH;
        end else if (status.raw_ok) begin
          cmd.stop_ld = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_FIRST;
          state_nxt   = W_HI;
        end else begin
          cmd.pos_skip = 1'b1;
          state_nxt    = W_RD;
        end
      end
      W_HI: begin
        cmd.hi_ld  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_FIRST1;
        state_nxt  = W_LO;
      end
      // Hold the new value; release the older one when the output is free
      W_LO: begin
        if (!status.have_pending || status.out_free) begin
          cmd.raw_take = 1'b1;
          state_nxt    = status.count_last ? W_FLUSH : W_RD;
        end
      end
      W_FLUSH: begin
        if (!status.have_pending) begin
          state_nxt = S_SYNC1;
        end else if (status.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_SYNC1;
        end
      end
      default: begin
        state_nxt = S_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SYNC1;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
